// File: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property with synchronous reset guard
`define ACLS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ACLS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ACLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/acls_pkg.sv
// ----------------------------------------------------------------------------
// acls_pkg
// Types, widths, codes and reset values of the activity classifier.
// ----------------------------------------------------------------------------
package acls_pkg;

  localparam int VAR_W   = 32;
  localparam int RANGE_W = 16;
  localparam int SHARE_W = 7;
  localparam int CLASS_W = 2;
  localparam int RUN_W   = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SLEEP    = 2'd0,
    CLS_QUIET    = 2'd1,
    CLS_GRAZING  = 2'd2,
    CLS_MOVEMENT = 2'd3
  } class_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_VAR_QUIET_STRICT   = 4'd0,
    REG_RANGE_QUIET_STRICT = 4'd1,
    REG_VAR_QUIET_LOOSE    = 4'd2,
    REG_RANGE_QUIET_LOOSE  = 4'd3,
    REG_VAR_MOVE_START     = 4'd4,
    REG_RANGE_MOVE_ENTER   = 4'd5,
    REG_VAR_MOVE           = 4'd6,
    REG_QUIET_TO_SLEEP     = 4'd7
  } reg_addr_t;

  // fixed guards
  localparam logic [RANGE_W-1:0] GUARD_RANGE_Z = 16'd450;
  localparam logic [SHARE_W-1:0] GUARD_SHARE   = 7'd55;
  localparam logic [RANGE_W-1:0] GRAZE_RANGE_Z = 16'd500;
  localparam logic [SHARE_W-1:0] GRAZE_SHARE   = 7'd60;

  // register reset values
  localparam logic [VAR_W-1:0]   RST_VAR_QUIET_STRICT   = 32'd1000;
  localparam logic [RANGE_W-1:0] RST_RANGE_QUIET_STRICT = 16'd500;
  localparam logic [VAR_W-1:0]   RST_VAR_QUIET_LOOSE    = 32'd5000;
  localparam logic [RANGE_W-1:0] RST_RANGE_QUIET_LOOSE  = 16'd900;
  localparam logic [VAR_W-1:0]   RST_VAR_MOVE_START     = 32'd8000;
  localparam logic [RANGE_W-1:0] RST_RANGE_MOVE_ENTER   = 16'd1200;
  localparam logic [VAR_W-1:0]   RST_VAR_MOVE           = 32'd20000;
  localparam logic [RUN_W-1:0]   RST_QUIET_TO_SLEEP     = 4'd10;

  typedef struct packed {
    logic [VAR_W-1:0]   var_quiet_strict;
    logic [RANGE_W-1:0] range_quiet_strict;
    logic [VAR_W-1:0]   var_quiet_loose;
    logic [RANGE_W-1:0] range_quiet_loose;
    logic [VAR_W-1:0]   var_move_start;
    logic [RANGE_W-1:0] range_move_enter;
    logic [VAR_W-1:0]   var_move;
    logic [RUN_W-1:0]   quiet_to_sleep;
  } thresh_t;

endpackage

// File: design/acls_ifs.sv
// ----------------------------------------------------------------------------
// acls channel interfaces
// Feature, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface acls_feat_if;
  logic                              valid;
  logic                              ready;
  logic [acls_pkg::VAR_W-1:0]        variance_total;
  logic [acls_pkg::RANGE_W-1:0]      range_vertical;
  logic [acls_pkg::RANGE_W-1:0]      range_all;
  logic [acls_pkg::SHARE_W-1:0]      vertical_share;

  modport source (output valid, variance_total, range_vertical, range_all, vertical_share,
                  input ready);
  modport sink   (input valid, variance_total, range_vertical, range_all, vertical_share,
                  output ready);
endinterface

interface acls_result_if;
  logic                         valid;
  logic                         ready;
  logic [acls_pkg::CLASS_W-1:0] burst_class;
  logic [acls_pkg::CLASS_W-1:0] held_state;
  logic                         persisted;
  logic                         changed;

  modport source (output valid, burst_class, held_state, persisted, changed, input ready);
  modport sink   (input valid, burst_class, held_state, persisted, changed, output ready);
endinterface

interface acls_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [acls_pkg::ADDR_W-1:0] addr;
  logic [acls_pkg::DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: design/acls_classify.sv
// ----------------------------------------------------------------------------
// acls_classify
// Burst class from features, thresholds and the committed state.
// ----------------------------------------------------------------------------
module acls_classify (
  input  acls_pkg::thresh_t                thr,
  input  acls_pkg::class_t                 held,
  input  logic [acls_pkg::VAR_W-1:0]       variance_total,
  input  logic [acls_pkg::RANGE_W-1:0]     range_vertical,
  input  logic [acls_pkg::RANGE_W-1:0]     range_all,
  input  logic [acls_pkg::SHARE_W-1:0]     vertical_share,
  output acls_pkg::class_t                 burst_class
);

  logic strict_quiet;
  logic loose_quiet;
  logic grazing;
  logic low_state;
  logic enter_move;

  assign strict_quiet = (variance_total < thr.var_quiet_strict) &&
                        (range_all < thr.range_quiet_strict);
  assign loose_quiet  = (variance_total < thr.var_quiet_loose) &&
                        (range_all < thr.range_quiet_loose) &&
                        ((range_vertical < acls_pkg::GUARD_RANGE_Z) ||
                         (vertical_share < acls_pkg::GUARD_SHARE));
  assign grazing      = (range_vertical > acls_pkg::GRAZE_RANGE_Z) &&
                        (vertical_share > acls_pkg::GRAZE_SHARE) &&
                        (variance_total < thr.var_move);
  assign low_state    = (held == acls_pkg::CLS_QUIET) || (held == acls_pkg::CLS_SLEEP);
  assign enter_move   = (variance_total > thr.var_move_start) ||
                        (range_all > thr.range_move_enter);

  always_comb begin
    if (strict_quiet || loose_quiet) begin
      burst_class = acls_pkg::CLS_QUIET;
    end else if (grazing) begin
      burst_class = acls_pkg::CLS_GRAZING;
    end else if (low_state && !enter_move) begin
      burst_class = acls_pkg::CLS_QUIET;
    end else begin
      burst_class = acls_pkg::CLS_MOVEMENT;
    end
  end

endmodule

// File: design/activity_classifier_hysteresis_core.sv
// ----------------------------------------------------------------------------
// activity_classifier_hysteresis_core
// Classifies bursts, commits repeated classes and counts quiet runs to sleep.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake   | payload
//  cfg       | in  | valid/ready | addr, data (register write)
//  features  | in  | valid/ready | variance_total, range_vertical, range_all, vertical_share
//  result    | out | valid/ready | burst_class, held_state, persisted, changed
//
//  one request per cycle unless the result stalls; path: input register, result register
//  committed state updates as a request moves into the result register
//  rst is synchronous; registers return to their default thresholds
//  a stalled result holds the result register; one more request waits in the input register
module activity_classifier_hysteresis_core (
  input  logic                clk,
  input  logic                rst,
  acls_cfg_if.sink            cfg,
  acls_feat_if.sink           features,
  acls_result_if.source       result
);

  acls_pkg::thresh_t thr;

  // input register
  logic                           s1_valid;
  logic [acls_pkg::VAR_W-1:0]     s1_variance_total;
  logic [acls_pkg::RANGE_W-1:0]   s1_range_vertical;
  logic [acls_pkg::RANGE_W-1:0]   s1_range_all;
  logic [acls_pkg::SHARE_W-1:0]   s1_vertical_share;

  // committed state
  acls_pkg::class_t               previous_class;
  logic                           previous_valid;
  logic [acls_pkg::RUN_W-1:0]     quiet_run;
  acls_pkg::class_t               current_state;

  acls_pkg::class_t               previous_class_next;
  logic [acls_pkg::RUN_W-1:0]     quiet_run_next;
  acls_pkg::class_t               current_state_next;

  // result register
  logic                           out_valid;
  acls_pkg::class_t               out_class;
  acls_pkg::class_t               out_held;
  logic                           out_persisted;
  logic                           out_changed;

  acls_pkg::class_t               cls;
  logic                           commit;
  logic                           changed_next;
  logic [acls_pkg::RUN_W:0]       run_inc;
  logic                           advance;
  logic                           fire;

  assign cfg.ready      = 1'b1;
  assign advance        = !out_valid || result.ready;
  assign fire           = s1_valid && advance;
  assign features.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.var_quiet_strict   <= acls_pkg::RST_VAR_QUIET_STRICT;
      thr.range_quiet_strict <= acls_pkg::RST_RANGE_QUIET_STRICT;
      thr.var_quiet_loose    <= acls_pkg::RST_VAR_QUIET_LOOSE;
      thr.range_quiet_loose  <= acls_pkg::RST_RANGE_QUIET_LOOSE;
      thr.var_move_start     <= acls_pkg::RST_VAR_MOVE_START;
      thr.range_move_enter   <= acls_pkg::RST_RANGE_MOVE_ENTER;
      thr.var_move           <= acls_pkg::RST_VAR_MOVE;
      thr.quiet_to_sleep     <= acls_pkg::RST_QUIET_TO_SLEEP;
    end else if (cfg.valid) begin
      unique case (acls_pkg::reg_addr_t'(cfg.addr))
        acls_pkg::REG_VAR_QUIET_STRICT:   thr.var_quiet_strict   <= cfg.data[31:0];
        acls_pkg::REG_RANGE_QUIET_STRICT: thr.range_quiet_strict <= cfg.data[15:0];
        acls_pkg::REG_VAR_QUIET_LOOSE:    thr.var_quiet_loose    <= cfg.data[31:0];
        acls_pkg::REG_RANGE_QUIET_LOOSE:  thr.range_quiet_loose  <= cfg.data[15:0];
        acls_pkg::REG_VAR_MOVE_START:     thr.var_move_start     <= cfg.data[31:0];
        acls_pkg::REG_RANGE_MOVE_ENTER:   thr.range_move_enter   <= cfg.data[15:0];
        acls_pkg::REG_VAR_MOVE:           thr.var_move           <= cfg.data[31:0];
        acls_pkg::REG_QUIET_TO_SLEEP:     thr.quiet_to_sleep     <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (features.ready) begin
      s1_valid <= features.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (features.valid && features.ready) begin
      s1_variance_total <= features.variance_total;
      s1_range_vertical <= features.range_vertical;
      s1_range_all      <= features.range_all;
      s1_vertical_share <= features.vertical_share;
    end
  end

  acls_classify u_classify (
    .thr            (thr),
    .held           (current_state),
    .variance_total (s1_variance_total),
    .range_vertical (s1_range_vertical),
    .range_all      (s1_range_all),
    .vertical_share (s1_vertical_share),
    .burst_class    (cls)
  );

  assign commit  = previous_valid && (previous_class == cls);
  assign run_inc = {1'b0, quiet_run} + {{acls_pkg::RUN_W{1'b0}}, 1'b1};

  always_comb begin
    previous_class_next = cls;
    quiet_run_next      = quiet_run;
    current_state_next  = current_state;
    if (commit) begin
      if (cls == acls_pkg::CLS_QUIET) begin
        if (run_inc >= {1'b0, thr.quiet_to_sleep}) begin
          current_state_next = acls_pkg::CLS_SLEEP;
          quiet_run_next     = '0;
        end else begin
          current_state_next = acls_pkg::CLS_QUIET;
          quiet_run_next     = run_inc[acls_pkg::RUN_W-1:0];
        end
      end else begin
        current_state_next = cls;
        quiet_run_next     = '0;
      end
    end
    changed_next = current_state_next != current_state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_class <= acls_pkg::CLS_MOVEMENT;
      previous_valid <= 1'b0;
      quiet_run      <= '0;
      current_state  <= acls_pkg::CLS_MOVEMENT;
    end else if (fire) begin
      previous_class <= previous_class_next;
      previous_valid <= 1'b1;
      quiet_run      <= quiet_run_next;
      current_state  <= current_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_class     <= cls;
      out_held      <= current_state_next;
      out_persisted <= commit;
      out_changed   <= changed_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.burst_class = out_class;
  assign result.held_state  = out_held;
  assign result.persisted   = out_persisted;
  assign result.changed     = out_changed;

endmodule

// File: design/acls_checker.sv
// ----------------------------------------------------------------------------
// acls_checker
// Port level checks of the activity classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acls_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [acls_pkg::CLASS_W-1:0] burst_class,
  input logic [acls_pkg::CLASS_W-1:0] held_state,
  input logic                         persisted,
  input logic                         changed
);

  logic                         seen;
  logic [acls_pkg::CLASS_W-1:0] last_class;
  logic [acls_pkg::CLASS_W-1:0] last_held;
  logic                         out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      last_class <= acls_pkg::CLS_MOVEMENT;
      last_held  <= acls_pkg::CLS_MOVEMENT;
    end else if (out_acc) begin
      seen       <= 1'b1;
      last_class <= burst_class;
      last_held  <= held_state;
    end
  end

  `ACLS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(held_state) && $stable(burst_class), "result dropped or changed while stalled")
  `ACLS_ASSERT_IMPL(a_first_not_persisted, clk, rst, out_acc && !seen, !persisted, "first request after reset committed")
  `ACLS_ASSERT_IMPL(a_persist_matches, clk, rst, out_acc && persisted, seen && (burst_class == last_class), "commit without matching previous class")
  `ACLS_ASSERT_IMPL(a_changed_flag, clk, rst, out_acc, changed == (held_state != last_held), "changed flag disagrees with held state")

endmodule

bind activity_classifier_hysteresis_core acls_checker u_acls_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .burst_class (result.burst_class),
  .held_state  (result.held_state),
  .persisted   (result.persisted),
  .changed     (result.changed)
);

// File: tb/activity_classifier_hysteresis_core_tb.sv
// ----------------------------------------------------------------------------
// activity_classifier_hysteresis_core_tb
// Drives feature bursts and threshold writes into the classifier and checks
// every result against a cycle-free model of the class, hysteresis, commit
// and quiet-run-to-sleep behavior. A directed table opens the run; random
// phases follow under several threshold settings with random stalls on both
// channels, a long receiver hold-off and drained pauses between phases.
// ----------------------------------------------------------------------------
module activity_classifier_hysteresis_core_tb;
  import acls_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int LATENCY       = 2;
  localparam int PHASES        = 12;
  localparam int PHASE_BURSTS  = 77;
  localparam int TAIL_STILL    = 8;
  localparam int HOLD_PHASE    = 2;
  localparam int STEADY_PHASE  = 3;
  localparam int HOLD_CYCLES   = 60;
  localparam int IDLE_PCT      = 6;
  localparam int LIMIT_TIME    = 4_000_000;
  localparam int DIRECTED_LEN  = 24;

  typedef struct packed {
    logic [VAR_W-1:0]   variance_total;
    logic [RANGE_W-1:0] range_vertical;
    logic [RANGE_W-1:0] range_all;
    logic [SHARE_W-1:0] vertical_share;
  } burst_t;

  typedef struct packed {
    class_t burst_class;
    class_t held_state;
    logic   persisted;
    logic   changed;
  } verdict_t;

  typedef struct packed {
    burst_t   b;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  typedef enum {K_STILL, K_LOOSE, K_GRAZE, K_MOVE, K_EDGE, K_NOISE} burst_kind_t;

  localparam verdict_t UNTYPED = '{CLS_SLEEP, CLS_SLEEP, 1'b0, 1'b0};
  localparam burst_t   ZERO_B  = '{32'd0, 16'd0, 16'd0, 7'd0};

  localparam dir_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{ZERO_B, 1'b1, '{CLS_QUIET, CLS_MOVEMENT, 1'b0, 1'b0}},
    '{ZERO_B, 1'b1, '{CLS_QUIET, CLS_QUIET, 1'b1, 1'b1}},
    '{'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'd127}, 1'b1,
      '{CLS_MOVEMENT, CLS_QUIET, 1'b0, 1'b0}},
    '{'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'd127}, 1'b1,
      '{CLS_MOVEMENT, CLS_MOVEMENT, 1'b1, 1'b1}},
    '{'{32'd10000, 16'd600, 16'd2000, 7'd101}, 1'b0, UNTYPED},
    '{'{32'd10000, 16'd600, 16'd2000, 7'd127}, 1'b0, UNTYPED},
    '{'{32'd3000, 16'd300, 16'd700, 7'd80}, 1'b0, UNTYPED},
    '{'{32'd3000, 16'd600, 16'd700, 7'd40}, 1'b0, UNTYPED},
    '{'{32'd3000, 16'd460, 16'd700, 7'd70}, 1'b0, UNTYPED},
    '{'{32'd9000, 16'd0, 16'd0, 7'd0}, 1'b0, UNTYPED},
    '{'{32'd6000, 16'd0, 16'd1300, 7'd0}, 1'b0, UNTYPED},
    '{'{32'd6000, 16'd0, 16'd1000, 7'd0}, 1'b0, UNTYPED},
    '{'{32'd999, 16'hFFFF, 16'd499, 7'd127}, 1'b0, UNTYPED},
    '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED},
    '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED},
    '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED},
    '{ZERO_B, 1'b0, UNTYPED}, '{ZERO_B, 1'b0, UNTYPED}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  acls_cfg_if    cfg_if ();
  acls_feat_if   feat_if ();
  acls_result_if res_if ();

  activity_classifier_hysteresis_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .features (feat_if),
    .result   (res_if)
  );

  // model state
  thresh_t      th;
  class_t       last_class;
  logic         seen_any;
  logic [3:0]   quiet_run;
  class_t       held;
  verdict_t     verdicts_due [$];

  int           errors = 0;
  logic         steady = 1'b0;
  logic         hold_req = 1'b0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  verdict_t     want;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #LIMIT_TIME;
    $display("activity_classifier_hysteresis_core_tb: done, errors");
    $finish;
  end

  function automatic class_t classify_burst(burst_t b);
    logic [SHARE_W-1:0] sh;
    sh = (b.vertical_share > 7'd100) ? 7'd100 : b.vertical_share;
    if (b.variance_total < th.var_quiet_strict && b.range_all < th.range_quiet_strict)
      return CLS_QUIET;
    if (b.variance_total < th.var_quiet_loose && b.range_all < th.range_quiet_loose &&
        (b.range_vertical < GUARD_RANGE_Z || sh < GUARD_SHARE))
      return CLS_QUIET;
    if (b.range_vertical > GRAZE_RANGE_Z && sh > GRAZE_SHARE && b.variance_total < th.var_move)
      return CLS_GRAZING;
    if (held == CLS_QUIET || held == CLS_SLEEP) begin
      if (b.variance_total > th.var_move_start || b.range_all > th.range_move_enter)
        return CLS_MOVEMENT;
      return CLS_QUIET;
    end
    return CLS_MOVEMENT;
  endfunction

  task automatic predict_burst(input burst_t b, output verdict_t v);
    class_t     c;
    class_t     nxt;
    logic       commit;
    logic [4:0] run;
    c = classify_burst(b);
    commit = seen_any && last_class == c;
    last_class = c;
    seen_any = 1'b1;
    v.changed = 1'b0;
    if (commit) begin
      nxt = c;
      if (c == CLS_QUIET) begin
        run = {1'b0, quiet_run} + 5'd1;
        if (run >= {1'b0, th.quiet_to_sleep}) begin
          nxt = CLS_SLEEP;
          run = '0;
        end
        quiet_run = run[3:0];
      end else begin
        quiet_run = '0;
      end
      if (nxt != held) begin
        held = nxt;
        v.changed = 1'b1;
      end
    end
    v.burst_class = c;
    v.held_state = held;
    v.persisted = commit;
  endtask

  function automatic logic [31:0] jitter(logic [31:0] x);
    return x + $urandom_range(0, 2) - 1;
  endfunction

  function automatic burst_t make_burst(burst_kind_t k);
    burst_t b;
    b.variance_total = $urandom();
    b.range_vertical = 16'($urandom());
    b.range_all = 16'($urandom());
    b.vertical_share = 7'($urandom_range(0, 100));
    case (k)
      K_STILL: begin
        b.variance_total = (th.var_quiet_strict == 0) ? '0 :
                           $urandom_range(0, th.var_quiet_strict - 1);
        b.range_all = (th.range_quiet_strict == 0) ? '0 :
                      16'($urandom_range(0, th.range_quiet_strict - 1));
        b.range_vertical = 16'($urandom_range(0, 1000));
      end
      K_LOOSE: begin
        b.variance_total = (th.var_quiet_loose == 0) ? '0 :
                           $urandom_range(0, th.var_quiet_loose - 1);
        b.range_all = (th.range_quiet_loose == 0) ? '0 :
                      16'($urandom_range(0, th.range_quiet_loose - 1));
        b.range_vertical = 16'($urandom_range(0, 700));
      end
      K_GRAZE: begin
        b.range_vertical = 16'($urandom_range(GRAZE_RANGE_Z, 3000));
        b.vertical_share = 7'($urandom_range(GRAZE_SHARE, 127));
        b.variance_total = (th.var_move == 0) ? '0 : $urandom_range(0, th.var_move - 1);
        b.range_all = 16'($urandom_range(0, 3000));
      end
      K_MOVE: begin
        b.variance_total = th.var_move_start + $urandom_range(0, 20000);
        b.range_all = 16'($urandom_range(0, 4000));
        b.range_vertical = 16'($urandom_range(0, 1000));
      end
      K_EDGE: begin
        case ($urandom_range(0, 3))
          0: b.variance_total = jitter(th.var_quiet_strict);
          1: b.variance_total = jitter(th.var_quiet_loose);
          2: b.variance_total = jitter(th.var_move_start);
          default: b.variance_total = jitter(th.var_move);
        endcase
        case ($urandom_range(0, 2))
          0: b.range_all = 16'(jitter(32'(th.range_quiet_strict)));
          1: b.range_all = 16'(jitter(32'(th.range_quiet_loose)));
          default: b.range_all = 16'(jitter(32'(th.range_move_enter)));
        endcase
        b.range_vertical = 16'(jitter($urandom_range(0, 1) ? 32'(GUARD_RANGE_Z) :
                                                                32'(GRAZE_RANGE_Z)));
        case ($urandom_range(0, 2))
          0: b.vertical_share = 7'(jitter(32'(GUARD_SHARE)));
          1: b.vertical_share = 7'(jitter(32'(GRAZE_SHARE)));
          default: b.vertical_share = 7'(jitter(32'd100));
        endcase
      end
      default: b.vertical_share = 7'($urandom_range(0, 127));
    endcase
    return b;
  endfunction

  task automatic offer_burst(input burst_t b, input logic typed, input verdict_t v);
    verdict_t got;
    feat_if.valid <= 1'b1;
    feat_if.variance_total <= b.variance_total;
    feat_if.range_vertical <= b.range_vertical;
    feat_if.range_all <= b.range_all;
    feat_if.vertical_share <= b.vertical_share;
    do @(posedge clk); while (!feat_if.ready);
    predict_burst(b, got);
    verdicts_due.push_back(typed ? v : got);
  endtask

  task automatic apply_reg(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    case (a)
      REG_VAR_QUIET_STRICT:   th.var_quiet_strict = d;
      REG_RANGE_QUIET_STRICT: th.range_quiet_strict = d[RANGE_W-1:0];
      REG_VAR_QUIET_LOOSE:    th.var_quiet_loose = d;
      REG_RANGE_QUIET_LOOSE:  th.range_quiet_loose = d[RANGE_W-1:0];
      REG_VAR_MOVE_START:     th.var_move_start = d;
      REG_RANGE_MOVE_ENTER:   th.range_move_enter = d[RANGE_W-1:0];
      REG_VAR_MOVE:           th.var_move = d;
      REG_QUIET_TO_SLEEP:     th.quiet_to_sleep = d[RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= a;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(a, d);
  endtask

  // upper bits of the narrow registers carry junk on purpose
  task automatic set_all(input logic [VAR_W-1:0] vqs, input logic [RANGE_W-1:0] rqs,
                         input logic [VAR_W-1:0] vql, input logic [RANGE_W-1:0] rql,
                         input logic [VAR_W-1:0] vme, input logic [RANGE_W-1:0] rme,
                         input logic [VAR_W-1:0] vm,  input logic [RUN_W-1:0] cnt);
    write_reg(REG_VAR_QUIET_STRICT, vqs);
    write_reg(REG_RANGE_QUIET_STRICT, {16'($urandom()), rqs});
    write_reg(REG_VAR_QUIET_LOOSE, vql);
    write_reg(REG_RANGE_QUIET_LOOSE, {16'($urandom()), rql});
    write_reg(REG_VAR_MOVE_START, vme);
    write_reg(REG_RANGE_MOVE_ENTER, {16'($urandom()), rme});
    write_reg(REG_VAR_MOVE, vm);
    write_reg(REG_QUIET_TO_SLEEP, {28'($urandom()), cnt});
    write_reg(ADDR_W'($urandom_range(int'(REG_QUIET_TO_SLEEP) + 1, (1 << ADDR_W) - 1)),
              $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_phase(input int p);
    logic [VAR_W-1:0] vqs;
    logic [RANGE_W-1:0] rqs;
    case (p)
      0: ;
      1: set_all(RST_VAR_QUIET_STRICT, RST_RANGE_QUIET_STRICT, RST_VAR_QUIET_LOOSE,
                 RST_RANGE_QUIET_LOOSE, RST_VAR_MOVE_START, RST_RANGE_MOVE_ENTER,
                 RST_VAR_MOVE, 4'd1);
      2: set_all(RST_VAR_QUIET_STRICT, RST_RANGE_QUIET_STRICT, RST_VAR_QUIET_LOOSE,
                 RST_RANGE_QUIET_LOOSE, RST_VAR_MOVE_START, RST_RANGE_MOVE_ENTER,
                 RST_VAR_MOVE, 4'd15);
      3: set_all('0, '0, '0, '0, '0, '0, '0, 4'd3);
      4: set_all('1, '1, '1, '1, '1, '1, '1, 4'd2);
      5: set_all(RST_VAR_QUIET_STRICT, RST_RANGE_QUIET_STRICT, RST_VAR_QUIET_LOOSE,
                 RST_RANGE_QUIET_LOOSE, RST_VAR_MOVE_START, RST_RANGE_MOVE_ENTER,
                 RST_VAR_MOVE, 4'd0);
      6: set_all(RST_VAR_QUIET_STRICT, RST_RANGE_QUIET_STRICT, RST_VAR_QUIET_LOOSE,
                 RST_RANGE_QUIET_LOOSE, RST_VAR_MOVE_START, RST_RANGE_MOVE_ENTER,
                 RST_VAR_MOVE, 4'd12);
      7: begin
        // sleep count lowered below the run in progress
        write_reg(REG_QUIET_TO_SLEEP, 32'd2);
        cfg_if.valid <= 1'b0;
      end
      default: begin
        vqs = $urandom_range(0, 3000);
        rqs = 16'($urandom_range(0, 800));
        set_all(vqs, rqs, vqs + $urandom_range(0, 6000), rqs + 16'($urandom_range(0, 800)),
                $urandom_range(0, 20000), 16'($urandom_range(0, 2000)),
                $urandom_range(0, 40000), 4'($urandom_range(1, 15)));
      end
    endcase
  endtask

  task automatic drain_results();
    feat_if.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (res_if.burst_class !== want.burst_class) begin
          $error("burst_class: expected %0d, got %0d", want.burst_class, res_if.burst_class);
          errors++;
        end
        if (res_if.held_state !== want.held_state) begin
          $error("held_state: expected %0d, got %0d", want.held_state, res_if.held_state);
          errors++;
        end
        if (res_if.persisted !== want.persisted) begin
          $error("persisted: expected %0d, got %0d", want.persisted, res_if.persisted);
          errors++;
        end
        if (res_if.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, res_if.changed);
          errors++;
        end
      end
    end
  end

  initial begin
    burst_kind_t kind;
    int          run_left;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    feat_if.valid = 1'b0;
    feat_if.variance_total = '0;
    feat_if.range_vertical = '0;
    feat_if.range_all = '0;
    feat_if.vertical_share = '0;
    res_if.ready = 1'b0;
    th = '{RST_VAR_QUIET_STRICT, RST_RANGE_QUIET_STRICT, RST_VAR_QUIET_LOOSE,
           RST_RANGE_QUIET_LOOSE, RST_VAR_MOVE_START, RST_RANGE_MOVE_ENTER,
           RST_VAR_MOVE, RST_QUIET_TO_SLEEP};
    last_class = CLS_MOVEMENT;
    seen_any = 1'b0;
    quiet_run = '0;
    held = CLS_MOVEMENT;
    kind = K_STILL;
    run_left = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_LEN; i++)
      offer_burst(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].v);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_phase(p);
      steady = (p == STEADY_PHASE);
      hold_req = (p == HOLD_PHASE);
      for (int n = 0; n < PHASE_BURSTS; n++) begin
        if (run_left == 0) begin
          kind = burst_kind_t'($urandom_range(int'(K_STILL), int'(K_NOISE)));
          run_left = $urandom_range(1, 14);
        end
        run_left--;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
          feat_if.valid <= 1'b0;
          @(posedge clk);
        end
        offer_burst(make_burst((n >= PHASE_BURSTS - TAIL_STILL) ? K_STILL : kind),
                    1'b0, UNTYPED);
      end
    end
    drain_results();

    if (errors == 0)
      $display("activity_classifier_hysteresis_core_tb: done, clean");
    else
      $display("activity_classifier_hysteresis_core_tb: done, errors");
    $finish;
  end

endmodule

// File: activity_classifier_hysteresis_core.f
+incdir+design
design/acls_pkg.sv
design/acls_ifs.sv
design/acls_classify.sv
design/activity_classifier_hysteresis_core.sv
design/acls_checker.sv
tb/activity_classifier_hysteresis_core_tb.sv
